// ===== hw/rtl/isou_pkg.sv =====
// ---------------------------------------------------------------------------
// isou_pkg: shared types and constants of the date-time to Unix seconds block
// Character codes, field positions, records passed between stages and the
// month offset table of the March-based civil day count.
// ---------------------------------------------------------------------------
package isou_pkg;

    localparam logic [4:0] FULL_LEN    = 5'd19;
    localparam logic [4:0] POS_DASH_Y  = 5'd4;
    localparam logic [4:0] POS_DASH_M  = 5'd7;
    localparam logic [4:0] POS_T       = 5'd10;
    localparam logic [4:0] POS_COLON_H = 5'd13;
    localparam logic [4:0] POS_COLON_M = 5'd16;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int MONTH_MAX  = 12;
    localparam int DAY_MAX    = 31;
    localparam int HOUR_MAX   = 23;
    localparam int MINUTE_MAX = 59;
    localparam int SECOND_MAX = 60;

    // Years are biased by one full 400-year cycle so all floors stay positive.
    localparam int YEAR_BIAS     = 400;
    localparam int DAYS_PER_YEAR = 365;
    localparam int DAYS_BIAS     = 719468 + 146097;
    localparam int RECIP_100     = 5243;
    localparam int RECIP_SHIFT   = 19;
    localparam int HOUR_SEC      = 3600;
    localparam int MINUTE_SEC    = 60;
    localparam int DAY_SEC       = 86400;

    localparam longint SECS_MIN = -64'sd62167219200;
    localparam longint SECS_MAX = 64'sd253402300800;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        ok;
    } rec_t;

    typedef struct packed {
        logic [21:0] p365;
        logic [7:0]  c100;
        logic [5:0]  c400;
        logic [11:0] s4;
        logic [8:0]  doy;
        logic [16:0] h_sec;
        logic [11:0] ms_sec;
        logic        ok;
    } part_t;

    typedef struct packed {
        logic signed [22:0] days;
        logic [16:0]        tod;
        logic               ok;
    } day_t;

    // Days from March 1 to the first of the given month.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/isou_parse.sv =====
// ---------------------------------------------------------------------------
// isou_parse: character front end
// Checks separators, accumulates the decimal fields and hands one record
// per string to the date stage when the last character arrives.
// ---------------------------------------------------------------------------
module isou_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_code,
    input  logic          is_last,
    output logic          rec_valid,
    input  logic          rec_ready,
    output isou_pkg::rec_t rec
);
    import isou_pkg::*;

    logic [4:0]  pos_reg, pos_step, pos_next;
    logic [13:0] year_reg, year_step, year_next;
    logic [6:0]  month_reg, month_step, month_next;
    logic [6:0]  day_reg, day_step, day_next;
    logic [6:0]  hour_reg, hour_step, hour_next;
    logic [6:0]  minute_reg, minute_step, minute_next;
    logic [6:0]  second_reg, second_step, second_next;
    logic        bad_reg, bad_step, bad_next;
    logic        rec_valid_reg, rec_valid_next;
    rec_t        rec_reg, rec_next;
    logic        accept, load, is_digit, ok;
    logic [3:0]  digit;

    assign accept   = in_valid && in_ready;
    assign load     = accept && is_last;
    assign in_ready = !rec_valid_reg || rec_ready;
    assign is_digit = (char_code >= CH_0) && (char_code <= CH_9);
    assign digit    = char_code[3:0];

    always_comb
    begin
        pos_step    = pos_reg;
        year_step   = year_reg;
        month_step  = month_reg;
        day_step    = day_reg;
        hour_step   = hour_reg;
        minute_step = minute_reg;
        second_step = second_reg;
        bad_step    = bad_reg;
        if (accept && (pos_reg < FULL_LEN))
        begin
            pos_step = pos_reg + 5'd1;
            case (pos_reg) inside
                POS_DASH_Y, POS_DASH_M:
                    if (char_code != CH_DASH) bad_step = 1'b1;
                POS_T:
                    if ((char_code != CH_T) && (char_code != CH_SPACE)) bad_step = 1'b1;
                POS_COLON_H, POS_COLON_M:
                    if (char_code != CH_COLON) bad_step = 1'b1;
                default:
                begin
                    if (!is_digit)
                        bad_step = 1'b1;
                    else if (pos_reg < POS_DASH_Y)
                        year_step = 14'(18'(year_reg) * 18'd10 + 18'(digit));
                    else if (pos_reg < POS_DASH_M)
                        month_step = 7'(11'(month_reg) * 11'd10 + 11'(digit));
                    else if (pos_reg < POS_T)
                        day_step = 7'(11'(day_reg) * 11'd10 + 11'(digit));
                    else if (pos_reg < POS_COLON_H)
                        hour_step = 7'(11'(hour_reg) * 11'd10 + 11'(digit));
                    else if (pos_reg < POS_COLON_M)
                        minute_step = 7'(11'(minute_reg) * 11'd10 + 11'(digit));
                    else
                        second_step = 7'(11'(second_reg) * 11'd10 + 11'(digit));
                end
            endcase
        end
    end

    assign ok = (pos_step == FULL_LEN) && !bad_step
             && (month_step >= 7'd1) && (month_step <= 7'(MONTH_MAX))
             && (day_step >= 7'd1) && (day_step <= 7'(DAY_MAX))
             && (hour_step <= 7'(HOUR_MAX)) && (minute_step <= 7'(MINUTE_MAX))
             && (second_step <= 7'(SECOND_MAX));

    // The string state starts over after the last character.
    always_comb
    begin
        pos_next    = load ? '0 : pos_step;
        year_next   = load ? '0 : year_step;
        month_next  = load ? '0 : month_step;
        day_next    = load ? '0 : day_step;
        hour_next   = load ? '0 : hour_step;
        minute_next = load ? '0 : minute_step;
        second_next = load ? '0 : second_step;
        bad_next    = load ? 1'b0 : bad_step;
        rec_valid_next = load ? 1'b1 : (rec_ready ? 1'b0 : rec_valid_reg);
        rec_next = rec_reg;
        if (load)
        begin
            rec_next.year   = year_step;
            rec_next.month  = month_step[3:0];
            rec_next.day    = day_step[4:0];
            rec_next.hour   = hour_step[4:0];
            rec_next.minute = minute_step[5:0];
            rec_next.second = second_step[5:0];
            rec_next.ok     = ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            bad_reg       <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            bad_reg       <= bad_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

// ===== hw/rtl/isou_days.sv =====
// ---------------------------------------------------------------------------
// isou_days: civil day count
// Two stages: the year products and floors, then the day sum and the time
// of day.
// ---------------------------------------------------------------------------
module isou_days (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  isou_pkg::rec_t rec,
    output logic           out_valid,
    input  logic           out_ready,
    output isou_pkg::day_t day_out
);
    import isou_pkg::*;

    logic        part_valid_reg, part_valid_next;
    logic        day_valid_reg, day_valid_next;
    logic        part_ready;
    part_t       part_reg, part_next;
    day_t        day_reg, day_next;
    logic [13:0] s;
    logic [11:0] s4;
    logic [26:0] prod100;
    logic [24:0] prod400;
    logic [24:0] days_sum;

    assign part_ready = !day_valid_reg || out_ready;
    assign in_ready   = !part_valid_reg || part_ready;

    // January and February count as months of the previous year.
    assign s       = rec.year + 14'(YEAR_BIAS) - ((rec.month <= 4'd2) ? 14'd1 : 14'd0);
    assign s4      = s[13:2];
    assign prod100 = 27'(s) * 27'(RECIP_100);
    assign prod400 = 25'(s4) * 25'(RECIP_100);

    always_comb
    begin
        part_next        = part_reg;
        part_valid_next  = part_ready ? 1'b0 : part_valid_reg;
        if (in_valid && in_ready)
        begin
            part_valid_next  = 1'b1;
            part_next.p365   = 22'(s) * 22'(DAYS_PER_YEAR);
            part_next.c100   = prod100[26:RECIP_SHIFT];
            part_next.c400   = prod400[24:RECIP_SHIFT];
            part_next.s4     = s4;
            part_next.doy    = month_offset(rec.month) + 9'(rec.day) - 9'd1;
            part_next.h_sec  = 17'(rec.hour) * 17'(HOUR_SEC);
            part_next.ms_sec = 12'(rec.minute) * 12'(MINUTE_SEC) + 12'(rec.second);
            part_next.ok     = rec.ok;
        end
    end

    assign days_sum = 25'(part_reg.p365) + 25'(part_reg.s4) - 25'(part_reg.c100)
                    + 25'(part_reg.c400) + 25'(part_reg.doy) - 25'(DAYS_BIAS);

    always_comb
    begin
        day_next       = day_reg;
        day_valid_next = out_ready ? 1'b0 : day_valid_reg;
        if (part_valid_reg && part_ready)
        begin
            day_valid_next = 1'b1;
            day_next.days  = $signed(days_sum[22:0]);
            day_next.tod   = part_reg.h_sec + 17'(part_reg.ms_sec);
            day_next.ok    = part_reg.ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
            day_valid_reg  <= 1'b0;
        end
        else
        begin
            part_valid_reg <= part_valid_next;
            day_valid_reg  <= day_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        day_reg  <= day_next;
    end

    assign out_valid = day_valid_reg;
    assign day_out   = day_reg;

endmodule

// ===== hw/rtl/isou_secs.sv =====
// ---------------------------------------------------------------------------
// isou_secs: seconds scaling and output register
// Multiplies the day count by the day length, adds the time of day and
// holds the result, zero for a rejected string, until the sink takes it.
// ---------------------------------------------------------------------------
module isou_secs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  isou_pkg::day_t day_in,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [38:0]    secs,
    output logic           ok
);
    import isou_pkg::*;

    logic               valid_reg, valid_next;
    logic [38:0]        secs_reg, secs_next;
    logic               ok_reg, ok_next;
    logic signed [40:0] days_ext;
    logic signed [40:0] secs_wide;

    assign in_ready  = !valid_reg || out_ready;
    assign days_ext  = 41'(day_in.days);
    assign secs_wide = days_ext * $signed(41'(DAY_SEC)) + $signed({24'b0, day_in.tod});

    always_comb
    begin
        secs_next  = secs_reg;
        ok_next    = ok_reg;
        valid_next = out_ready ? 1'b0 : valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            ok_next    = day_in.ok;
            secs_next  = day_in.ok ? secs_wide[38:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        secs_reg <= secs_next;
        ok_reg   <= ok_next;
    end

    assign out_valid = valid_reg;
    assign secs      = secs_reg;
    assign ok        = ok_reg;

endmodule

// ===== hw/rtl/iso8601_to_unix_seconds.sv =====
// ---------------------------------------------------------------------------
// iso8601_to_unix_seconds: ISO 8601 date-time string to Unix seconds
// From the last character the result passes the parser record, year-part, day and output registers.
// Throughput: one character per cycle; stalls only when all four stage
// registers hold results and the sink is not ready.
// The per-character work is a compare and a decimal accumulate; the date
// arithmetic is spread over three stages after the parser register.
// Reset clears the string state and all stage valid flags; no clearing pass.
// ---------------------------------------------------------------------------
module iso8601_to_unix_seconds (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [38:0] unix_seconds, [39] zero
    output logic [0:0]  m_axis_tuser    // [0] valid_res
);
    import isou_pkg::*;

    logic        rec_valid, rec_ready;
    rec_t        rec;
    logic        day_valid, day_ready;
    day_t        day;
    logic [38:0] secs;
    logic        ok;

    isou_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .char_code (s_axis_tdata),
        .is_last   (s_axis_tlast),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    isou_days u_days (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rec_valid),
        .in_ready  (rec_ready),
        .rec       (rec),
        .out_valid (day_valid),
        .out_ready (day_ready),
        .day_out   (day)
    );

    isou_secs u_secs (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (day_valid),
        .in_ready  (day_ready),
        .day_in    (day),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .secs      (secs),
        .ok        (ok)
    );

    assign m_axis_tdata = {1'b0, secs};
    assign m_axis_tuser = ok;

    // A rejected string always reports zero seconds.
    a_zero_when_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
        else $error("rejected string with nonzero seconds");

    // An accepted string stays inside the four-digit year span.
    a_secs_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            ($signed(m_axis_tdata[38:0]) >= SECS_MIN) &&
            ($signed(m_axis_tdata[38:0]) <= SECS_MAX))
        else $error("seconds outside the representable date span");

    // The last character of a string always produces a record.
    a_last_makes_record: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> rec_valid)
        else $error("last character did not produce a record");

    // A record waiting for the date stage is never dropped.
    a_record_held: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid && $stable(rec))
        else $error("stalled record lost");

endmodule

// ===== tb/iso8601_to_unix_seconds_tb.sv =====
// ---------------------------------------------------------------------------
// iso8601_to_unix_seconds_tb: self-checking bench for the date-time converter
// Streams date-time strings one character per request, predicts the Unix
// seconds and the accept flag of every string, and checks each result in
// order while both stream sides pause and stall at random.
// ---------------------------------------------------------------------------
module iso8601_to_unix_seconds_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_CHARS = 600;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_DASH  = 8'h2D;
    localparam logic [7:0] C_T     = 8'h54;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_ZULU  = 8'h5A;

    localparam logic [4:0] STAMP_LEN  = 5'd19;
    localparam logic [4:0] POS_DASH1  = 5'd4;
    localparam logic [4:0] POS_DASH2  = 5'd7;
    localparam logic [4:0] POS_SEP    = 5'd10;
    localparam logic [4:0] POS_COLON1 = 5'd13;
    localparam logic [4:0] POS_COLON2 = 5'd16;

    typedef struct packed {
        logic [38:0] secs;
        logic        ok;
    } stamp_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    // Predicted parser state.
    logic [4:0]  pos_r;
    logic [13:0] year_r;
    logic [6:0]  month_r;
    logic [6:0]  day_r;
    logic [6:0]  hour_r;
    logic [6:0]  minute_r;
    logic [6:0]  second_r;
    logic        bad_r;

    stamp_t      stamp_q[$];
    logic [7:0]  line_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          burst_left;
    bit          steady;
    int          stall_left = 0;
    int          rx_phase = 0;

    iso8601_to_unix_seconds dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic void clear_parser();
        pos_r    = '0;
        year_r   = '0;
        month_r  = '0;
        day_r    = '0;
        hour_r   = '0;
        minute_r = '0;
        second_r = '0;
        bad_r    = 1'b0;
    endfunction

    // Days from the March-based civil calendar, then seconds from the epoch.
    function automatic longint epoch_seconds();
        longint y;
        longint m;
        longint d;
        longint sy;
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        longint days;
        y = longint'(year_r);
        m = longint'(month_r);
        d = longint'(day_r);
        sy = y - ((m <= 2) ? 1 : 0);
        era = ((sy >= 0) ? sy : sy - 399) / 400;
        yoe = sy - era * 400;
        doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        return days * 86400 + longint'(hour_r) * 3600 + longint'(minute_r) * 60
               + longint'(second_r);
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic last);
        logic       is_dig;
        logic [3:0] dig;
        logic       ok;
        longint     secs;
        stamp_t     stamp;
        is_dig = (c >= C_ZERO) && (c <= C_NINE);
        dig = is_dig ? 4'(c - C_ZERO) : 4'd0;
        if (pos_r < STAMP_LEN)
        begin
            if (pos_r == POS_DASH1 || pos_r == POS_DASH2)
            begin
                if (c != C_DASH) bad_r = 1'b1;
            end
            else if (pos_r == POS_SEP)
            begin
                if (c != C_T && c != C_SPACE) bad_r = 1'b1;
            end
            else if (pos_r == POS_COLON1 || pos_r == POS_COLON2)
            begin
                if (c != C_COLON) bad_r = 1'b1;
            end
            else if (!is_dig)
                bad_r = 1'b1;
            else if (pos_r < POS_DASH1)
                year_r = 14'(year_r * 10 + dig);
            else if (pos_r < POS_DASH2)
                month_r = 7'(month_r * 10 + dig);
            else if (pos_r < POS_SEP)
                day_r = 7'(day_r * 10 + dig);
            else if (pos_r < POS_COLON1)
                hour_r = 7'(hour_r * 10 + dig);
            else if (pos_r < POS_COLON2)
                minute_r = 7'(minute_r * 10 + dig);
            else
                second_r = 7'(second_r * 10 + dig);
            pos_r = pos_r + 5'd1;
        end
        if (last)
        begin
            ok = (pos_r >= STAMP_LEN) && !bad_r && month_r >= 1 && month_r <= 12
                 && day_r >= 1 && day_r <= 31 && hour_r <= 23 && minute_r <= 59
                 && second_r <= 60;
            secs = ok ? epoch_seconds() : 0;
            stamp.secs = secs[38:0];
            stamp.ok = ok;
            stamp_q.push_back(stamp);
            clear_parser();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sends one character; outside steady mode a new burst starts with a random pause.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 7) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        parse_char(c, last);
        burst_left--;
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_char(line_q[i], i == line_q.size() - 1);
    endtask

    function automatic void put_num(input int value, input int digits);
        int div;
        div = 1;
        for (int i = 1; i < digits; i++) div *= 10;
        for (int i = 0; i < digits; i++)
        begin
            line_q.push_back(8'(C_ZERO + (value / div) % 10));
            div /= 10;
        end
    endfunction

    function automatic void build_stamp(input int y, input int mo, input int d,
                                        input int h, input int mi, input int s,
                                        input logic [7:0] sep);
        line_q.delete();
        put_num(y, 4);
        line_q.push_back(C_DASH);
        put_num(mo, 2);
        line_q.push_back(C_DASH);
        put_num(d, 2);
        line_q.push_back(sep);
        put_num(h, 2);
        line_q.push_back(C_COLON);
        put_num(mi, 2);
        line_q.push_back(C_COLON);
        put_num(s, 2);
    endfunction

    task automatic test_accepted_stamps();
        build_stamp(1970, 1, 1, 0, 0, 0, C_T);
        send_line();
        build_stamp(0, 1, 1, 0, 0, 0, C_T);
        send_line();
        build_stamp(9999, 12, 31, 23, 59, 60, C_T);
        send_line();
        build_stamp(2000, 2, 29, 12, 34, 56, C_SPACE);
        send_line();
        build_stamp(1969, 12, 31, 23, 59, 59, C_T);
        send_line();
        // A day past the end of its month just rolls forward.
        build_stamp(2023, 2, 31, 7, 8, 9, C_T);
        send_line();
        build_stamp(2021, 3, 1, 1, 2, 3, C_T);
        line_q.push_back(C_DOT);
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        line_q.push_back(C_ZULU);
        send_line();
        // A long tail keeps the position counter saturated.
        build_stamp(1900, 2, 28, 23, 0, 0, C_T);
        repeat (30) line_q.push_back(8'($urandom_range(0, 255)));
        send_line();
    endtask

    task automatic test_rejected_stamps();
        logic [4:0] sep_pos[5];
        sep_pos = '{POS_DASH1, POS_DASH2, POS_SEP, POS_COLON1, POS_COLON2};
        build_stamp(2024, 1, 1, 0, 0, 0, C_T);
        void'(line_q.pop_back());
        send_line();
        line_q.delete();
        line_q.push_back(C_NINE);
        send_line();
        build_stamp(2024, 1, 1, 0, 0, 0, C_T);
        line_q[0] = C_PLUS;
        send_line();
        build_stamp(2024, 1, 1, 0, 0, 0, C_T);
        line_q[5] = C_MINUS;
        send_line();
        build_stamp(2024, 1, 1, 0, 0, 0, C_T);
        line_q[17] = C_SPACE;
        send_line();
        build_stamp(2024, 1, 1, 0, 0, 0, C_T);
        line_q[8] = 8'hFF;
        send_line();
        build_stamp(2024, 1, 1, 0, 0, 0, C_T);
        line_q[12] = 8'h00;
        send_line();
        foreach (sep_pos[k])
        begin
            build_stamp(2024, 6, 15, 12, 30, 30, C_T);
            line_q[sep_pos[k]] = C_DOT;
            send_line();
        end
        build_stamp(2024, 0, 1, 0, 0, 0, C_T);
        send_line();
        build_stamp(2024, 13, 1, 0, 0, 0, C_T);
        send_line();
        build_stamp(2024, 1, 0, 0, 0, 0, C_T);
        send_line();
        build_stamp(2024, 1, 32, 0, 0, 0, C_T);
        send_line();
        build_stamp(2024, 1, 1, 24, 0, 0, C_T);
        send_line();
        build_stamp(2024, 1, 1, 0, 60, 0, C_T);
        send_line();
        build_stamp(2024, 1, 1, 0, 0, 61, C_T);
        send_line();
    endtask

    // Mostly well-formed strings with random fields, mixed at random with corrupt,
    // cut short or out-of-range strings and some plain noise.
    task automatic test_random_stamps();
        int sent;
        int kind;
        logic [7:0] sep;
        sent = 0;
        while (sent < RANDOM_CHARS)
        begin
            kind = $urandom_range(0, 99);
            sep = $urandom_range(0, 1) ? C_T : C_SPACE;
            if (kind < 70)
                build_stamp($urandom_range(0, 9999), $urandom_range(1, 12),
                            $urandom_range(1, 31), $urandom_range(0, 23),
                            $urandom_range(0, 59), $urandom_range(0, 60), sep);
            else
                build_stamp($urandom_range(0, 9999), $urandom_range(0, 99),
                            $urandom_range(0, 99), $urandom_range(0, 99),
                            $urandom_range(0, 99), $urandom_range(0, 99), sep);
            if (kind < 60)
            begin
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 12))
                        line_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind >= 80 && kind < 90)
                line_q[$urandom_range(0, 18)] = 8'($urandom_range(0, 255));
            else if (kind >= 90 && kind < 96)
                line_q = line_q[0:$urandom_range(0, 17)];
            else if (kind >= 96)
            begin
                line_q.delete();
                repeat ($urandom_range(1, 40))
                    line_q.push_back(8'($urandom_range(0, 255)));
            end
            sent += line_q.size();
            send_line();
        end
    endtask

    // Receiver: phases of constant readiness alternate with random stalls.
    always @(posedge clk)
    begin
        rx_phase++;
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_phase[7])
            m_axis_tready <= 1'b1;
        else
        begin
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 20);
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        stamp_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (stamp_q.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata, '0);
            else
            begin
                want = stamp_q.pop_front();
                if (m_axis_tuser[0] !== want.ok)
                    report_mismatch("valid_res", 40'(m_axis_tuser), 40'(want.ok));
                if (m_axis_tdata[38:0] !== want.secs)
                    report_mismatch("unix_seconds", 40'(m_axis_tdata[38:0]),
                                    40'(want.secs));
                if (m_axis_tdata[39] !== 1'b0)
                    report_mismatch("tdata padding", 40'(m_axis_tdata[39]), '0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        burst_left = 0;
        steady     = 1'b0;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_accepted_stamps();
        test_rejected_stamps();
        test_random_stamps();

        s_axis_tvalid <= 1'b0;
        while (stamp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/isou_pkg.sv
hw/rtl/isou_parse.sv
hw/rtl/isou_days.sv
hw/rtl/isou_secs.sv
hw/rtl/iso8601_to_unix_seconds.sv
tb/iso8601_to_unix_seconds_tb.sv
